### hw/rtl/stepper_ramp_driver_macros.svh
// Assertion macros shared by the stepper ramp driver RTL.
`ifndef STEPPER_RAMP_DRIVER_MACROS_SVH
`define STEPPER_RAMP_DRIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SRD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SRD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/stpr_pkg.sv
// Types, codes and the half-step coil table for the stepper ramp driver.
`timescale 1ns / 1ps

package stpr_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    localparam logic [1:0] CMD_MOVE  = 2'd3;

    localparam logic [1:0] MODE_STOP  = 2'd0;
    localparam logic [1:0] MODE_ACCEL = 2'd1;
    localparam logic [1:0] MODE_RUN   = 2'd2;
    localparam logic [1:0] MODE_DECEL = 2'd3;

    localparam logic [1:0] CFG_MAX_SPEED  = 2'd0;
    localparam logic [1:0] CFG_ACCEL_STEP = 2'd1;
    localparam logic [1:0] CFG_DECEL_STEP = 2'd2;

    localparam logic [7:0] PERIOD_TOP  = 8'hFF;
    localparam logic [7:0] DECEL_LIMIT = 8'hF0;

    localparam logic [7:0] RST_MAX_SPEED  = 8'd155;
    localparam logic [7:0] RST_ACCEL_STEP = 8'd1;
    localparam logic [7:0] RST_DECEL_STEP = 8'd1;

    typedef struct packed {
        logic [7:0] tick_count;
        logic [7:0] period;
        logic [2:0] phase;
        logic [1:0] mode;
        logic       run;
        logic       enable;
    } stpr_state_t;

    typedef struct packed {
        logic [7:0] max_speed;
        logic [7:0] accel_step;
        logic [7:0] decel_step;
    } stpr_cfg_t;

    function automatic logic [3:0] coil_lookup(input logic [2:0] phase);
        logic [3:0] pattern;
        begin
            case (phase)
                3'd0: pattern = 4'h8;
                3'd1: pattern = 4'hA;
                3'd2: pattern = 4'h2;
                3'd3: pattern = 4'h6;
                3'd4: pattern = 4'h4;
                3'd5: pattern = 4'h5;
                3'd6: pattern = 4'h1;
                default: pattern = 4'h9;
            endcase
            return pattern;
        end
    endfunction

endpackage

### hw/rtl/stpr_step.sv
// Next-state logic for one command: timer compare, phase advance and speed ramp.
`timescale 1ns / 1ps

module stpr_step import stpr_pkg::*; (
    input  stpr_state_t st,
    input  stpr_cfg_t   cfg,
    input  logic [1:0]  cmd,
    input  logic [15:0] step_count,
    output stpr_state_t st_next,
    output logic        taken
);

    logic [7:0] floor_period;
    logic [7:0] accel_period;
    logic [8:0] decel_sum;
    logic [7:0] decel_period;

    assign floor_period = PERIOD_TOP - cfg.max_speed;
    assign accel_period = (st.period > cfg.accel_step) ? (st.period - cfg.accel_step) : 8'd0;
    assign decel_sum    = {1'b0, st.period} + {1'b0, cfg.decel_step};
    assign decel_period = decel_sum[8] ? PERIOD_TOP : decel_sum[7:0];

    always_comb begin
        st_next = st;
        taken   = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (st.run) begin
                    if (st.tick_count == st.period) begin
                        st_next.tick_count = 8'd0;
                        st_next.enable     = 1'b1;
                        st_next.phase      = st.phase + 3'd1;
                        taken              = 1'b1;
                        // The ramp acts on the mode held before this step.
                        case (st.mode)
                            MODE_STOP: begin
                                st_next.enable = 1'b0;
                                st_next.run    = 1'b0;
                            end
                            MODE_ACCEL: begin
                                st_next.period = accel_period;
                                if (accel_period <= floor_period) begin
                                    st_next.mode = MODE_RUN;
                                end
                            end
                            MODE_DECEL: begin
                                st_next.period = decel_period;
                                if (decel_period >= DECEL_LIMIT) begin
                                    st_next.mode = MODE_STOP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else begin
                        st_next.tick_count = st.tick_count + 8'd1;
                    end
                end
            end
            CMD_START: begin
                st_next.period = PERIOD_TOP;
                st_next.run    = 1'b1;
                st_next.mode   = MODE_ACCEL;
            end
            CMD_STOP: begin
                st_next.mode = MODE_DECEL;
            end
            default: begin
                if (step_count == 16'd0) begin
                    st_next.mode = MODE_STOP;
                end else if (step_count == 16'd1) begin
                    st_next.mode = MODE_DECEL;
                end else begin
                    st_next.mode = MODE_ACCEL;
                end
            end
        endcase
    end

endmodule

### hw/rtl/stepper_ramp_driver.sv
// Top level of the half-step stepper driver with trapezoidal speed ramp.
//
//   port group | direction | contents
//   s_*        | in        | cmd, step_count (valid/ready)
//   m_*        | out       | coil_pattern, motor_enable, timer_running,
//              |           | ramp_state, step_period, step_taken (valid/ready)
//   cfg_*      | in        | write enable, register index, 8-bit data
//
// Each command is applied by loading the state registers and the result register
// at the same edge, so one transaction is accepted per clock while s_ready is high.
// The result register is the only buffer; s_ready falls only while a result
// waits and m_ready is low. Reset is synchronous to aclk, active low, and
// restores the state and the configuration registers at once.
`timescale 1ns / 1ps
`include "stepper_ramp_driver_macros.svh"

module stepper_ramp_driver import stpr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [15:0] s_step_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_coil_pattern,
    output logic        m_motor_enable,
    output logic        m_timer_running,
    output logic [1:0]  m_ramp_state,
    output logic [7:0]  m_step_period,
    output logic        m_step_taken,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_wdata
);

    stpr_state_t state_reg;
    stpr_state_t state_next;
    stpr_cfg_t   cfg_reg;
    logic        taken_next;
    logic        s_accept;
    logic        m_valid_reg;
    logic [3:0]  coil_reg;
    logic        enable_reg;
    logic        running_reg;
    logic [1:0]  ramp_reg;
    logic [7:0]  period_out_reg;
    logic        taken_reg;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    stpr_step u_step (
        .st         (state_reg),
        .cfg        (cfg_reg),
        .cmd        (s_cmd),
        .step_count (s_step_count),
        .st_next    (state_next),
        .taken      (taken_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.tick_count <= 8'd0;
            state_reg.period     <= PERIOD_TOP;
            state_reg.phase      <= 3'd0;
            state_reg.mode       <= MODE_STOP;
            state_reg.run        <= 1'b0;
            state_reg.enable     <= 1'b0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Indexes past the last register are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_speed  <= RST_MAX_SPEED;
            cfg_reg.accel_step <= RST_ACCEL_STEP;
            cfg_reg.decel_step <= RST_DECEL_STEP;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MAX_SPEED:  cfg_reg.max_speed  <= cfg_wdata;
                CFG_ACCEL_STEP: cfg_reg.accel_step <= cfg_wdata;
                CFG_DECEL_STEP: cfg_reg.decel_step <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= s_accept || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            coil_reg       <= coil_lookup(state_next.phase);
            enable_reg     <= state_next.enable;
            running_reg    <= state_next.run;
            ramp_reg       <= state_next.mode;
            period_out_reg <= state_next.period;
            taken_reg      <= taken_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_coil_pattern  = coil_reg;
    assign m_motor_enable  = enable_reg;
    assign m_timer_running = running_reg;
    assign m_ramp_state    = ramp_reg;
    assign m_step_period   = period_out_reg;
    assign m_step_taken    = taken_reg;

    `SRD_ASSERT_IMPLY(a_step_enables, aclk, aresetn, m_valid_reg && taken_reg && (ramp_reg != MODE_STOP), enable_reg, "step outside stop left the motor disabled")
    `SRD_ASSERT_NEXT(a_start_loads, aclk, aresetn, s_accept && (s_cmd == CMD_START), state_reg.run && (state_reg.period == PERIOD_TOP) && (state_reg.mode == MODE_ACCEL), "start did not load period and run")
    `SRD_ASSERT_NEXT(a_halted_tick, aclk, aresetn, s_accept && (s_cmd == CMD_TICK) && !state_reg.run, $stable(state_reg) && !taken_reg, "tick while halted changed state")
    `SRD_ASSERT_IMPLY(a_taken_is_tick, aclk, aresetn, s_accept && taken_next, (s_cmd == CMD_TICK) && state_reg.run, "step taken without a running tick")

endmodule
